// ===== design/utf8_casefold_substring_search_defines.svh =====
// assertion macros for the utf8 case-folding substring search block
// used by the top level only; no other dependencies
`ifndef UTF8_CASEFOLD_SUBSTRING_SEARCH_DEFINES_SVH
`define UTF8_CASEFOLD_SUBSTRING_SEARCH_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UCSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define UCSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ucss_pkg.sv =====
// shared types, codes and the case-fold function of the substring search block
// no dependencies
package ucss_pkg;

	localparam int MAX_PATTERN_DEF = 32;
	localparam int MAX_TEXT_DEF    = 65536;
	localparam int QUEUE_DEPTH     = 4;
	localparam int CHAR_W          = 32;
	localparam int POS_W           = 16;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_TEXT   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		KIND_START,
		KIND_APPEND,
		KIND_TEXT
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [CHAR_W-1:0] code;
		logic              last;
	} entry_t;

	typedef struct packed {
		logic       done;
		logic [8:0] count;
	} back_status_t;

	function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] code);
		logic [7:0] b0;
		logic [7:0] b1;
		b0 = code[7:0];
		b1 = code[15:8];
		if (b0 < 8'h80) begin
			if (b0 >= 8'h41 && b0 <= 8'h5A) begin
				b0 = b0 + 8'd32;
			end
		end else if (b0 == 8'hD0) begin
			if (b1 >= 8'h90 && b1 <= 8'h9F) begin
				b1 = b1 + 8'd32;
			end else if (b1 >= 8'hA0 && b1 <= 8'hAF) begin
				b0 = 8'hD1;
				b1 = b1 - 8'hA0 + 8'h80;
			end else if (b1 == 8'h81) begin
				b0 = 8'hD1;
				b1 = 8'h91;
			end
		end
		return {code[31:16], b1, b0};
	endfunction

endpackage

// ===== design/ucss_front.sv =====
// front end: decodes the input word, folds text characters, feeds the queue
// depends on ucss_pkg
module ucss_front (
	input  logic                       fold_case,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [ucss_pkg::CHAR_W-1:0] s_tdata,
	input  logic [1:0]                 s_tuser,
	input  logic                       s_tlast,
	output logic                       push,
	output ucss_pkg::entry_t           push_entry,
	input  logic                       q_ready
);

	assign s_tready = q_ready;

	always_comb begin
		push_entry.code = s_tdata;
		push_entry.last = s_tlast;
		push_entry.kind = ucss_pkg::KIND_START;
		push = s_tvalid && q_ready;
		unique case (s_tuser)
			ucss_pkg::OP_START: begin
				push_entry.kind = ucss_pkg::KIND_START;
			end
			ucss_pkg::OP_APPEND: begin
				push_entry.kind = ucss_pkg::KIND_APPEND;
			end
			ucss_pkg::OP_TEXT: begin
				push_entry.kind = ucss_pkg::KIND_TEXT;
				if (fold_case) begin
					push_entry.code = ucss_pkg::fold_char(s_tdata);
				end
			end
			ucss_pkg::OP_UNUSED: begin
				push = 1'b0;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

endmodule

// ===== design/ucss_queue.sv =====
// short flop queue between front and back end
// depends on ucss_pkg
module ucss_queue #(
	parameter int DEPTH = ucss_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ucss_pkg::entry_t push_entry,
	output logic             q_ready,
	input  logic             pop,
	output logic             q_valid,
	output ucss_pkg::entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ucss_pkg::entry_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign q_ready = (fill_q != CW'(DEPTH));
	assign q_valid = (fill_q != '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && q_ready;
	assign do_pop  = pop && q_valid;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== design/ucss_back.sv =====
// back end: pattern cells, shift-and match bank, text counter, result register
// depends on ucss_pkg
module ucss_back #(
	parameter int MAX_PATTERN = ucss_pkg::MAX_PATTERN_DEF,
	parameter int MAX_TEXT    = ucss_pkg::MAX_TEXT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fold_case,
	input  logic                        q_valid,
	input  ucss_pkg::entry_t            head,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic                        res_found,
	output logic [ucss_pkg::POS_W-1:0]  res_position,
	output ucss_pkg::back_status_t      status
);

	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int POS_W = ucss_pkg::POS_W;
	localparam int LIMIT_RAW = (MAX_TEXT - 1 > 65535) ? 65535 : MAX_TEXT - 1;
	localparam logic [POS_W-1:0] TEXT_LIMIT = POS_W'(LIMIT_RAW);

	logic [ucss_pkg::CHAR_W-1:0] pattern_q [MAX_PATTERN];
	logic [CW-1:0]          count_q;
	logic [MAX_PATTERN-1:0] match_q;
	logic [POS_W-1:0]       text_index_q;
	logic                   done_q;
	logic                   m_valid_q;
	logic                   found_q;
	logic [POS_W-1:0]       position_q;

	logic [MAX_PATTERN-1:0] new_match;
	logic                   hit;
	logic [POS_W:0]         idx_p1;
	logic [POS_W:0]         cnt_ext;
	logic [POS_W:0]         start_pos;
	logic                   is_text;
	logic                   produce;
	logic                   produce_found;
	logic [POS_W-1:0]       produce_pos;

	assign pop      = q_valid && (!m_valid_q || m_tready);
	assign is_text  = pop && (head.kind == ucss_pkg::KIND_TEXT) && !done_q;
	assign m_tvalid = m_valid_q;
	assign res_found    = found_q;
	assign res_position = position_q;
	assign status.done  = done_q;
	assign status.count = 9'(count_q);

	// one cell per pattern position
	always_comb begin
		logic [ucss_pkg::CHAR_W-1:0] p;
		logic prev;
		hit = 1'b0;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			p = fold_case ? ucss_pkg::fold_char(pattern_q[j]) : pattern_q[j];
			prev = (j == 0) ? 1'b1 : match_q[(j == 0) ? 0 : j - 1];
			new_match[j] = (p == head.code) && prev && (CW'(j) < count_q);
			if (count_q == CW'(j + 1)) begin
				hit = new_match[j];
			end
		end
	end

	always_comb begin
		idx_p1    = {1'b0, text_index_q} + 1'b1;
		cnt_ext   = (POS_W + 1)'(count_q);
		start_pos = (idx_p1 >= cnt_ext) ? idx_p1 - cnt_ext : '0;
		produce       = 1'b0;
		produce_found = 1'b0;
		produce_pos   = '0;
		if (is_text) begin
			if (count_q == '0) begin
				produce       = 1'b1;
				produce_found = 1'b1;
			end else if (hit) begin
				produce       = 1'b1;
				produce_found = 1'b1;
				produce_pos   = start_pos[POS_W-1:0];
			end else if (head.last) begin
				produce = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			match_q      <= '0;
			text_index_q <= '0;
			done_q       <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (produce) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (head.kind)
					ucss_pkg::KIND_START: begin
						count_q      <= '0;
						match_q      <= '0;
						text_index_q <= '0;
						done_q       <= 1'b0;
					end
					ucss_pkg::KIND_APPEND: begin
						if (count_q < CW'(MAX_PATTERN)) begin
							count_q <= count_q + 1'b1;
						end
						match_q      <= '0;
						text_index_q <= '0;
						done_q       <= 1'b0;
					end
					ucss_pkg::KIND_TEXT: begin
						if (!done_q) begin
							if (count_q == '0) begin
								done_q <= 1'b1;
							end else begin
								match_q <= new_match;
								if (hit || head.last) begin
									done_q <= 1'b1;
								end
								if (text_index_q < TEXT_LIMIT) begin
									text_index_q <= text_index_q + 1'b1;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind == ucss_pkg::KIND_APPEND && count_q < CW'(MAX_PATTERN)) begin
			pattern_q[count_q[IW-1:0]] <= head.code;
		end
		if (produce) begin
			found_q    <= produce_found;
			position_q <= produce_pos;
		end
	end

endmodule

// ===== design/utf8_casefold_substring_search.sv =====
// top level of the utf8 case-folding substring search block
// depends on ucss_pkg, ucss_front, ucss_queue, ucss_back and the defines header
//
// input words on s_*: s_tuser is the op (start, append pattern char, text char),
// s_tdata the utf-8 char (first byte lowest, zero padded), s_tlast the last text char.
// result words on m_*: m_tdata bit 0 is found, bits 16:1 the match start position.
// a start word clears pattern and search; an append word adds a pattern char
// (dropped past MAX_PATTERN) and restarts the scan; text words run the match bank.
// one result per search: found with its start index, or not found on the last
// text char; text words after that are ignored until the next start or append.
// fold_case is written through fold_case_we/fold_case_wdata; the user must do so while
// idle, the block does not enforce it. a text word passes the queue, then the result
// register, before its result is valid. throughput: one word per cycle, set by the update
// of the shift-and cells, unless a result waits on a low m_tready: then the result register
// holds, the queue fills and s_tready drops; the four-entry queue lets front and back stall
// apart. reset clears pattern count, cells, text index and fold_case.
`include "utf8_casefold_substring_search_defines.svh"

module utf8_casefold_substring_search #(
	parameter int MAX_PATTERN = ucss_pkg::MAX_PATTERN_DEF,
	parameter int MAX_TEXT    = ucss_pkg::MAX_TEXT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fold_case_we,
	input  logic        fold_case_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // char_code[31:0]
	input  logic [1:0]  s_tuser,   // op[1:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // found[0], position[16:1], zero[23:17]
);

	logic                         fold_case_q;
	logic                         push;
	ucss_pkg::entry_t             push_entry;
	logic                         q_ready;
	logic                         q_valid;
	logic                         pop;
	ucss_pkg::entry_t             head;
	logic                         res_found;
	logic [ucss_pkg::POS_W-1:0]   res_position;
	ucss_pkg::back_status_t       status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_case_q <= 1'b0;
		end else if (fold_case_we) begin
			fold_case_q <= fold_case_wdata;
		end
	end

	ucss_front u_front (
		.fold_case  (fold_case_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready)
	);

	ucss_queue #(
		.DEPTH (ucss_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready),
		.pop        (pop),
		.q_valid    (q_valid),
		.head       (head)
	);

	ucss_back #(
		.MAX_PATTERN (MAX_PATTERN),
		.MAX_TEXT    (MAX_TEXT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fold_case    (fold_case_q),
		.q_valid      (q_valid),
		.head         (head),
		.pop          (pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.res_found    (res_found),
		.res_position (res_position),
		.status       (status)
	);

	assign m_tdata = {7'b0, res_position, res_found};

	`UCSS_ASSERT_NOW(a_notfound_pos_zero, m_tvalid && !m_tdata[0], m_tdata[16:1] == 16'd0, "not-found result with nonzero position")
	`UCSS_ASSERT_NEXT(a_start_clears, pop && head.kind == ucss_pkg::KIND_START, status.count == 9'd0 && !status.done, "start word did not clear the search")
	`UCSS_ASSERT_NEXT(a_append_grows, pop && head.kind == ucss_pkg::KIND_APPEND && status.count < 9'(MAX_PATTERN), status.count == $past(status.count) + 9'd1 && !status.done, "append word did not extend the pattern")
	`UCSS_ASSERT_NOW(a_result_sets_done, $rose(m_tvalid), status.done, "result given while search not done")

endmodule

// ===== verif/utf8_casefold_substring_search_test.sv =====
// self-checking testbench for utf8_casefold_substring_search: start, append and text words
// go in, each match report is checked against a built-in shift-and predictor with fold_case
// depends on ucss_pkg and the block's rtl only
module utf8_casefold_substring_search_test;

	localparam int PAT_CAP = 32;
	localparam int TEXT_SAT = 65535;
	localparam int TARGET_WORDS = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct packed {
		logic        found;
		logic [15:0] pos;
	} match_t;

	class match_predictor;
		bit fold_on;
		logic [31:0] pat_chars [PAT_CAP];
		int unsigned pat_len;
		bit [PAT_CAP-1:0] cells;
		int unsigned text_pos;
		bit done;
		match_t expected_matches [$];
		int unsigned words;
		int unsigned results_seen;
		int unsigned errors;

		function new();
			fold_on = 1'b0;
			pat_len = 0;
			words = 0;
			results_seen = 0;
			errors = 0;
			restart_scan();
		endfunction

		function void restart_scan();
			cells = '0;
			text_pos = 0;
			done = 1'b0;
		endfunction

		function logic [31:0] to_lower(input logic [31:0] w);
			logic [7:0] lead;
			logic [7:0] trail;
			lead = w[7:0];
			trail = w[15:8];
			if (lead >= 8'h41 && lead <= 8'h5A) begin
				lead = lead + 8'h20;
			end else if (lead == 8'hD0) begin
				// cyrillic capitals, split over two lead bytes once lowered
				if (trail >= 8'h90 && trail <= 8'h9F) begin
					trail = trail + 8'h20;
				end else if (trail >= 8'hA0 && trail <= 8'hAF) begin
					lead = 8'hD1;
					trail = trail - 8'h20;
				end else if (trail == 8'h81) begin
					lead = 8'hD1;
					trail = 8'h91;
				end
			end
			return {w[31:16], trail, lead};
		endfunction

		function void push_match(input logic hit, input logic [15:0] pos);
			match_t m;
			m.found = hit;
			m.pos = pos;
			expected_matches.push_back(m);
			done = 1'b1;
		endfunction

		function void take_word(input logic [1:0] op, input logic [31:0] code, input logic last);
			logic [31:0] c;
			logic [31:0] p;
			int j;
			int unsigned start;
			case (op)
				ucss_pkg::OP_START: begin
					words++;
					pat_len = 0;
					restart_scan();
				end
				ucss_pkg::OP_APPEND: begin
					words++;
					if (pat_len < PAT_CAP) begin
						pat_chars[pat_len] = code;
						pat_len++;
					end
					restart_scan();
				end
				ucss_pkg::OP_TEXT: begin
					if (!done) begin
						words++;
						if (pat_len == 0) begin
							push_match(1'b1, 16'd0);
						end else begin
							c = fold_on ? to_lower(code) : code;
							for (j = int'(pat_len) - 1; j >= 0; j--) begin
								p = fold_on ? to_lower(pat_chars[j]) : pat_chars[j];
								cells[j] = (p == c) && ((j == 0) ? 1'b1 : cells[j-1]);
							end
							if (cells[pat_len-1]) begin
								start = (text_pos + 1 >= pat_len) ? text_pos + 1 - pat_len : 0;
								push_match(1'b1, start[15:0]);
							end else if (last) begin
								push_match(1'b0, 16'd0);
							end
							if (text_pos < TEXT_SAT) begin
								text_pos++;
							end
						end
					end
				end
				default: ;
			endcase
		endfunction

		task report(input string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_match(input logic [23:0] word);
			match_t want;
			if (expected_matches.size() == 0) begin
				report($sformatf("result with none pending: found %0b position %0d",
					word[0], word[16:1]));
				return;
			end
			want = expected_matches.pop_front();
			results_seen++;
			if (word[0] !== want.found) begin
				report($sformatf("found %0b, predicted %0b", word[0], want.found));
			end
			if (word[16:1] !== want.pos) begin
				report($sformatf("position %0d, predicted %0d", word[16:1], want.pos));
			end
		endtask

		function int unsigned pending();
			return expected_matches.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        fold_case_we;
	logic        fold_case_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // char_code[31:0]
	logic [1:0]  s_tuser;   // op[1:0]
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // found[0], position[16:1], zero[23:17]

	match_predictor pred;
	bit src_gaps;
	bit sink_gaps;
	int unsigned sink_hold;
	int unsigned cycles;

	utf8_casefold_substring_search u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.fold_case_we    (fold_case_we),
		.fold_case_wdata (fold_case_wdata),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= LIMIT_CYCLES) begin
				$display("timeout after %0d cycles", cycles);
				$display("utf8_casefold_substring_search_test: errors");
				$finish;
			end
		end
	end

	// result side: check accepted words, then pick the next ready
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				pred.check_match(m_tdata);
			end
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				sink_hold--;
			end else begin
				m_tready <= !(sink_gaps && $urandom_range(99) < 24);
			end
		end
	end

	// letter pairs: latin a b z, cyrillic a pe er ya yo
	function automatic logic [31:0] letter(input int unsigned k, input bit up);
		case (k)
			0: return up ? 32'h0000_0041 : 32'h0000_0061;
			1: return up ? 32'h0000_0042 : 32'h0000_0062;
			2: return up ? 32'h0000_005A : 32'h0000_007A;
			3: return up ? 32'h0000_90D0 : 32'h0000_B0D0;
			4: return up ? 32'h0000_9FD0 : 32'h0000_BFD0;
			5: return up ? 32'h0000_A0D0 : 32'h0000_80D1;
			6: return up ? 32'h0000_AFD0 : 32'h0000_8FD1;
			default: return up ? 32'h0000_81D0 : 32'h0000_91D1;
		endcase
	endfunction

	function automatic logic [31:0] noise_char();
		logic [31:0] w;
		logic [7:0] b;
		b = 8'($urandom_range(255));
		w = letter($urandom_range(7), 1'($urandom_range(1)));
		case ($urandom_range(9))
			0: w = $urandom();
			1, 2: begin
				case ($urandom_range(7))
					0: w = 32'h0000_0040;
					1: w = 32'h0000_005B;
					2: w = 32'h0000_8FD0;
					3: w = 32'h0000_80D0;
					4: w = 32'h0000_82D0;
					5: w = {16'h0000, b, 8'hD0};
					6: w = 32'h00AC_82E2;
					default: w = 32'h8D98_9FF0;
				endcase
			end
			3: w[31:16] = 16'($urandom());
			default: ;
		endcase
		return w;
	endfunction

	task automatic send_word(input logic [1:0] op, input logic [31:0] code, input logic last);
		while (src_gaps && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= code;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		pred.take_word(op, code, last);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pred.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_fold(input bit v);
		fold_case_we <= 1'b1;
		fold_case_wdata <= v;
		@(posedge clk);
		pred.fold_on = v;
		fold_case_we <= 1'b0;
	endtask

	task automatic run_search();
		int unsigned pat_idx [PAT_CAP+2];
		bit pat_up [PAT_CAP+2];
		int plen;
		int tlen;
		int at;
		int j;
		bit embed;
		logic [31:0] c;
		if ($urandom_range(99) < 8) begin
			send_word(ucss_pkg::OP_UNUSED, $urandom(), 1'($urandom_range(1)));
		end
		send_word(ucss_pkg::OP_START, $urandom(), 1'($urandom_range(1)));
		plen = ($urandom_range(99) < 8) ? $urandom_range(30, 34) : $urandom_range(0, 5);
		for (j = 0; j < plen; j++) begin
			pat_idx[j] = $urandom_range(7);
			pat_up[j] = 1'($urandom_range(1));
			send_word(ucss_pkg::OP_APPEND, letter(pat_idx[j], pat_up[j]),
				1'($urandom_range(1)));
		end
		embed = (plen > 0) && ($urandom_range(99) < 60);
		tlen = embed ? plen + $urandom_range(0, 8) : $urandom_range(1, 12);
		at = embed ? $urandom_range(0, tlen - plen) : tlen;
		for (j = 0; j < tlen; j++) begin
			if ($urandom_range(99) < 4) begin
				send_word(ucss_pkg::OP_APPEND, noise_char(), 1'b0);
			end
			if (j >= at && j < at + plen) begin
				c = letter(pat_idx[j-at],
					($urandom_range(1) == 1) ? pat_up[j-at] : 1'($urandom_range(1)));
			end else begin
				c = noise_char();
			end
			send_word(ucss_pkg::OP_TEXT, c, j == tlen - 1);
		end
		if ($urandom_range(99) < 15) begin
			send_word(ucss_pkg::OP_TEXT, noise_char(), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		int phase;
		int k;
		pred = new();
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		sink_hold = 0;
		arst_n <= 1'b0;
		fold_case_we <= 1'b0;
		fold_case_wdata <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ucss_pkg::OP_START;
		s_tlast <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// exact compare
		write_fold(1'b0);
		send_word(ucss_pkg::OP_START, 32'h0000_0000, 1'b0);
		send_word(ucss_pkg::OP_TEXT, letter(0, 0), 1'b0);
		send_word(ucss_pkg::OP_TEXT, letter(1, 0), 1'b1);
		send_word(ucss_pkg::OP_START, 32'hFFFF_FFFF, 1'b1);
		send_word(ucss_pkg::OP_APPEND, letter(0, 1), 1'b0);
		send_word(ucss_pkg::OP_APPEND, letter(1, 0), 1'b0);
		send_word(ucss_pkg::OP_TEXT, letter(0, 0), 1'b0);
		send_word(ucss_pkg::OP_TEXT, letter(0, 1), 1'b0);
		send_word(ucss_pkg::OP_TEXT, letter(1, 0), 1'b0);
		send_word(ucss_pkg::OP_UNUSED, 32'hFFFF_FFFF, 1'b1);
		send_word(ucss_pkg::OP_START, 32'h0000_0000, 1'b0);
		send_word(ucss_pkg::OP_APPEND, 32'hFFFF_FFFF, 1'b0);
		send_word(ucss_pkg::OP_TEXT, 32'h0000_0000, 1'b1);
		settle();

		// folded compare, latin and cyrillic
		write_fold(1'b1);
		send_word(ucss_pkg::OP_START, 32'h0000_0000, 1'b0);
		send_word(ucss_pkg::OP_APPEND, letter(2, 1), 1'b0);
		send_word(ucss_pkg::OP_APPEND, letter(6, 1), 1'b0);
		send_word(ucss_pkg::OP_APPEND, letter(7, 1), 1'b0);
		send_word(ucss_pkg::OP_TEXT, letter(2, 0), 1'b0);
		send_word(ucss_pkg::OP_TEXT, letter(6, 0), 1'b0);
		send_word(ucss_pkg::OP_TEXT, letter(7, 0), 1'b0);
		send_word(ucss_pkg::OP_START, 32'h0000_0000, 1'b0);
		send_word(ucss_pkg::OP_APPEND, letter(4, 1), 1'b0);
		send_word(ucss_pkg::OP_TEXT, letter(5, 0), 1'b0);
		send_word(ucss_pkg::OP_APPEND, letter(0, 0), 1'b0);
		send_word(ucss_pkg::OP_TEXT, letter(4, 0), 1'b0);
		send_word(ucss_pkg::OP_TEXT, letter(0, 1), 1'b1);
		send_word(ucss_pkg::OP_START, 32'h0000_0000, 1'b0);
		send_word(ucss_pkg::OP_APPEND, letter(1, 1), 1'b0);
		send_word(ucss_pkg::OP_TEXT, letter(0, 0), 1'b1);
		send_word(ucss_pkg::OP_TEXT, letter(1, 0), 1'b0);
		settle();

		phase = 0;
		while (pred.words < TARGET_WORDS) begin
			src_gaps = (phase != 2);
			sink_gaps = (phase != 2);
			repeat (5) run_search();
			settle();
			write_fold(phase[0]);
			if (phase == 3) begin
				// output stall long enough to fill the queue and block the input
				src_gaps = 1'b0;
				sink_hold = 300;
				for (k = 0; k < 20; k++) begin
					send_word(ucss_pkg::OP_START, $urandom(), 1'b0);
					send_word(ucss_pkg::OP_TEXT, noise_char(), k[0]);
				end
				settle();
			end
			phase++;
		end

		if (pred.pending() != 0) begin
			pred.report($sformatf("%0d match reports never arrived", pred.pending()));
		end
		$display("covered %0d search words and %0d match reports, exact and folded compare,",
			pred.words, pred.results_seen);
		$display("pattern overflow, restarts mid-search and a long output stall");
		if (pred.errors == 0) begin
			$display("utf8_casefold_substring_search_test: clean");
		end else begin
			$display("utf8_casefold_substring_search_test: errors");
		end
		$finish;
	end
endmodule
